[hw/rtl/fan_tachometer_speed_meter_assert.svh]
// assertion macros shared by the rtl, clocked on clk and quiet during rst
`ifndef FAN_TACHOMETER_SPEED_METER_ASSERT_SVH
`define FAN_TACHOMETER_SPEED_METER_ASSERT_SVH

// condition in the same cycle
`define FTS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// condition in the next cycle
`define FTS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/fts_pkg.sv]
package fts_pkg;

  localparam int RING_DEPTH    = 10;
  localparam int TIMER_RATE_HZ = 1000000;
  localparam int SLOT_W        = $clog2(RING_DEPTH);

  localparam int TIME_W  = 32;
  localparam int GAP_W   = 16;
  localparam int LIMIT_W = 4;
  localparam int SPEED_W = 16;
  localparam int CFG_DATA_W = 16;

  localparam logic [GAP_W-1:0]   MIN_GAP_RESET = 16'd2000;
  localparam logic [LIMIT_W-1:0] STALE_RESET   = 4'd8;
  localparam logic [LIMIT_W-1:0] TICK_SAT      = 4'd15;
  localparam logic [SPEED_W-1:0] SPEED_SAT     = 16'hFFFF;

  // (depth-1) ticks per span, scaled to hundredths of hz
  localparam longint unsigned SPEED_NUM =
    longint'(RING_DEPTH - 1) * longint'(TIMER_RATE_HZ) * 64'd100;
  localparam int NUM_W = $clog2(SPEED_NUM + 1);
  localparam int CNT_W = $clog2(NUM_W);

  typedef enum logic [1:0] {
    OP_EDGE    = 2'd0,
    OP_TICK    = 2'd1,
    OP_MEASURE = 2'd2
  } op_t;

  typedef enum logic [0:0] {
    CFG_MIN_GAP     = 1'b0,
    CFG_STALE_LIMIT = 1'b1
  } cfg_index_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_NEW,
    S_SPAN,
    S_DIV,
    S_PUT
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

[hw/rtl/fts_in_if.sv]
interface fts_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [31:0] edge_time_us;

  modport source(output valid, operation, edge_time_us, input ready);
  modport sink(input valid, operation, edge_time_us, output ready);
endinterface

[hw/rtl/fts_out_if.sv]
interface fts_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] speed_centihz;
  logic        stalled;

  modport source(output valid, speed_centihz, stalled, input ready);
  modport sink(input valid, speed_centihz, stalled, output ready);
endinterface

[hw/rtl/fan_tachometer_speed_meter.sv]
// fan tachometer speed meter
// item channel (fts_in_if sink): one operation per transfer. a tach edge carries
// its microsecond timestamp and is kept only if it lands more than min_gap_us
// after the last kept edge (wrapping 32-bit difference); a slow tick advances
// the stale count; a measure request yields exactly one result transfer.
// result channel (fts_out_if source): speed_centihz and stalled, measure only.
// config port: cfg_we with cfg_index 0 writes min_gap_us, 1 writes stale_limit,
// taken at any edge; write only while no measure is in flight.
// edges and ticks are handled at their transfer and the next item follows
// straight away. a live measure runs from its transfer to the result being
// presented through two ring reads on the single read port (oldest, then
// newest), one span subtract, then the bit-serial divider, one quotient bit
// per cycle. a stale measure or zero span skips the divider. no item is taken
// while a measure is in flight.
// the result sits in an output register; while the receiver stalls a finished
// result waits there, edges and ticks keep flowing, and a later measure waits in
// its final state until the register drains.
// reset: ring reads as zero through per-slot valid bits (no clearing pass),
// write slot, stale count and last edge time zero, min_gap_us 2000, limit 8.
module fan_tachometer_speed_meter (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  fts_pkg::cfg_index_t               cfg_index,
  input  logic [fts_pkg::CFG_DATA_W-1:0]    cfg_data,
  fts_in_if.sink                            item,
  fts_out_if.source                         result
);

  // control state
  fts_pkg::state_t                  state;
  fts_pkg::state_t                  state_next;
  logic [fts_pkg::GAP_W-1:0]        min_gap_us;
  logic [fts_pkg::LIMIT_W-1:0]      stale_limit;
  logic [fts_pkg::SLOT_W-1:0]       write_slot;
  logic [fts_pkg::LIMIT_W-1:0]      ticks_since_edge;
  logic [fts_pkg::TIME_W-1:0]       last_time;
  logic [fts_pkg::RING_DEPTH-1:0]   ring_valid;
  logic                             out_valid;

  // datapath registers
  logic [fts_pkg::SLOT_W-1:0]       rd_addr_q;
  logic [fts_pkg::TIME_W-1:0]       oldest;
  logic [fts_pkg::SPEED_W-1:0]      res_speed;
  logic                             res_stalled;
  logic [fts_pkg::SPEED_W-1:0]      out_speed;
  logic                             out_stalled;

  // combinational
  logic                             xfer;
  logic                             is_edge;
  logic                             is_tick;
  logic                             is_measure;
  logic                             is_stale;
  logic                             stale_take;
  logic [fts_pkg::TIME_W-1:0]       gap;
  logic                             keep_edge;
  logic [fts_pkg::SLOT_W-1:0]       newest_slot;
  logic [fts_pkg::SLOT_W-1:0]       rd_addr;
  logic [fts_pkg::TIME_W-1:0]       rd_data;
  logic [fts_pkg::TIME_W-1:0]       rd_value;
  logic [fts_pkg::TIME_W-1:0]       span;
  logic                             div_start;
  logic                             load_out;
  fts_pkg::div_status_t             div_st;
  logic [fts_pkg::SPEED_W-1:0]      div_speed;

  assign item.ready = (state == fts_pkg::S_IDLE);
  assign xfer       = item.valid && item.ready;
  assign is_edge    = item.operation == fts_pkg::OP_EDGE;
  assign is_tick    = item.operation == fts_pkg::OP_TICK;
  assign is_measure = item.operation == fts_pkg::OP_MEASURE;
  assign is_stale   = ticks_since_edge >= stale_limit;
  assign stale_take = xfer && is_measure && is_stale;

  // wrapping gap to the last kept edge
  assign gap       = item.edge_time_us - last_time;
  assign keep_edge = xfer && is_edge && (gap > {{(fts_pkg::TIME_W-fts_pkg::GAP_W){1'b0}},
                                                 min_gap_us});

  // newest entry sits just behind the write slot, oldest at it
  assign newest_slot = (write_slot == '0) ? fts_pkg::SLOT_W'(fts_pkg::RING_DEPTH - 1)
                                          : write_slot - 1'b1;
  assign rd_addr     = (state == fts_pkg::S_IDLE) ? write_slot : newest_slot;
  // slots never written since reset or a stale clear read as zero
  assign rd_value    = ring_valid[rd_addr_q] ? rd_data : '0;
  assign span        = rd_value - oldest;

  fts_ram #(
    .WIDTH(fts_pkg::TIME_W),
    .DEPTH(fts_pkg::RING_DEPTH)
  ) u_ring (
    .clk  (clk),
    .we   (keep_edge),
    .waddr(write_slot),
    .wdata(item.edge_time_us),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  fts_div u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (div_start),
    .divisor(span),
    .status (div_st),
    .speed  (div_speed)
  );

  // next state and strobes
  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    load_out   = 1'b0;
    case (state)
      fts_pkg::S_IDLE: begin
        if (xfer && is_measure) begin
          state_next = is_stale ? fts_pkg::S_PUT : fts_pkg::S_RD_NEW;
        end
      end
      fts_pkg::S_RD_NEW: begin
        state_next = fts_pkg::S_SPAN;
      end
      fts_pkg::S_SPAN: begin
        if (span == '0) begin
          state_next = fts_pkg::S_PUT;
        end else begin
          div_start  = 1'b1;
          state_next = fts_pkg::S_DIV;
        end
      end
      fts_pkg::S_DIV: begin
        if (div_st.done) begin
          state_next = fts_pkg::S_PUT;
        end
      end
      fts_pkg::S_PUT: begin
        if (!out_valid || result.ready) begin
          load_out   = 1'b1;
          state_next = fts_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = fts_pkg::S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= fts_pkg::S_IDLE;
      min_gap_us       <= fts_pkg::MIN_GAP_RESET;
      stale_limit      <= fts_pkg::STALE_RESET;
      write_slot       <= '0;
      ticks_since_edge <= '0;
      last_time        <= '0;
      ring_valid       <= '0;
      out_valid        <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_we) begin
        if (cfg_index == fts_pkg::CFG_MIN_GAP) begin
          min_gap_us <= cfg_data[fts_pkg::GAP_W-1:0];
        end else begin
          stale_limit <= cfg_data[fts_pkg::LIMIT_W-1:0];
        end
      end

      if (keep_edge) begin
        ring_valid[write_slot] <= 1'b1;
        write_slot <= (write_slot == fts_pkg::SLOT_W'(fts_pkg::RING_DEPTH - 1))
                      ? '0 : write_slot + 1'b1;
        ticks_since_edge <= '0;
        last_time        <= item.edge_time_us;
      end

      if (xfer && is_tick && ticks_since_edge != fts_pkg::TICK_SAT) begin
        ticks_since_edge <= ticks_since_edge + 1'b1;
      end

      // stale measure: pin the count and drop the whole ring
      if (stale_take) begin
        ticks_since_edge <= stale_limit;
        ring_valid       <= '0;
      end

      if (load_out) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    rd_addr_q <= rd_addr;
    if (state == fts_pkg::S_RD_NEW) begin
      oldest <= rd_value;
    end
    if (xfer && is_measure) begin
      res_speed   <= '0;
      res_stalled <= is_stale;
    end else if (state == fts_pkg::S_DIV && div_st.done) begin
      res_speed <= div_speed;
    end
    if (load_out) begin
      out_speed   <= res_speed;
      out_stalled <= res_stalled;
    end
  end

  assign result.valid         = out_valid;
  assign result.speed_centihz = out_speed;
  assign result.stalled       = out_stalled;

  // checks
  `include "fan_tachometer_speed_meter_assert.svh"

  `FTS_ASSERT_SAME(a_div_owned, div_st.done, state == fts_pkg::S_DIV, "stray divider done")
  `FTS_ASSERT_SAME(a_div_run, state == fts_pkg::S_DIV, div_st != '0, "divider idle")
  `FTS_ASSERT_NEXT(a_stale_clear, stale_take, ring_valid == '0, "ring not cleared")
  `FTS_ASSERT_SAME(a_stalled_zero, out_valid && out_stalled, out_speed == '0, "speed on stall")

endmodule

[hw/rtl/fts_ram.sv]
module fts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/fts_div.sv]
// restoring divider, constant dividend shifted in one bit per cycle
module fts_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [fts_pkg::TIME_W-1:0]      divisor,
  output fts_pkg::div_status_t            status,
  output logic [fts_pkg::SPEED_W-1:0]     speed
);

  logic [fts_pkg::NUM_W-1:0]  qsr;
  logic [fts_pkg::TIME_W-1:0] rem;
  logic [fts_pkg::TIME_W-1:0] dvs;
  logic [fts_pkg::CNT_W-1:0]  cnt;
  logic                       busy;
  logic                       done;

  logic [fts_pkg::TIME_W:0]   rem_shift;
  logic [fts_pkg::TIME_W:0]   rem_diff;
  logic                       ge;

  always_comb begin
    rem_shift = {rem, qsr[fts_pkg::NUM_W-1]};
    rem_diff  = rem_shift - {1'b0, dvs};
    ge        = rem_shift >= {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == fts_pkg::CNT_W'(fts_pkg::NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      qsr <= fts_pkg::NUM_W'(fts_pkg::SPEED_NUM);
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      rem <= ge ? rem_diff[fts_pkg::TIME_W-1:0] : rem_shift[fts_pkg::TIME_W-1:0];
      qsr <= {qsr[fts_pkg::NUM_W-2:0], ge};
    end
  end

  assign status.busy = busy;
  assign status.done = done;
  // quotient above 16 bits saturates
  assign speed = (|qsr[fts_pkg::NUM_W-1:fts_pkg::SPEED_W]) ? fts_pkg::SPEED_SAT
                                                          : qsr[fts_pkg::SPEED_W-1:0];

endmodule
